>>> rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ADD_TERMINATOR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_BYTE_ORDER_MARK = 2'd1;

    localparam logic [15:0] BYTE_ORDER_MARK = 16'hFEFF;
    localparam logic [20:0] PLANE_ONE_BASE  = 21'h10000;
    localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        last_in_run;
        logic        text_done;
    } t_out_item;

    // work for the back end, one entry per accepted byte that yields results
    typedef struct packed {
        logic        bom;
        logic [1:0]  num_units;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        term;
        logic        marker;
        logic        eot;
    } t_job;

endpackage

>>> rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Byte decoder: tracks sequence state and config, and forms one job per byte that yields results.
// ----------------------------------------------------------------------------
module u2u_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  u2u_pkg::t_in_item             i_in,
    input  logic                          i_cfg_wr,
    input  logic [u2u_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    output logic                          o_job_push,
    output u2u_pkg::t_job                 o_job
);
    import u2u_pkg::*;

    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_point, n_point;
    logic        r_bom_sent, n_bom_sent;
    logic        r_add_term;
    logic        r_add_bom;

    logic [7:0]  b;
    logic [20:0] shifted;
    logic [20:0] cp;
    logic [20:0] offs;
    logic        has_pt;
    logic        emit_bom;
    logic        term;
    logic        marker;

    assign b       = i_in.text_byte;
    assign shifted = {r_point[14:0], b[5:0]};
    assign offs    = cp - PLANE_ONE_BASE;

    always_comb begin
        n_pending = r_pending;
        n_point   = r_point;
        has_pt    = 1'b0;
        cp        = {13'd0, b};
        if (r_pending != 2'd0) begin
            n_pending = r_pending - 2'd1;
            cp        = shifted;
            if (r_pending == 2'd1) begin
                has_pt  = 1'b1;
                n_point = '0;
            end else begin
                n_point = shifted;
            end
        end else if (b[7:3] == 5'b11110) begin
            n_point   = {18'd0, b[2:0]};
            n_pending = 2'd3;
        end else if (b[7:4] == 4'b1110) begin
            n_point   = {17'd0, b[3:0]};
            n_pending = 2'd2;
        end else if (b[7:5] == 3'b110) begin
            n_point   = {16'd0, b[4:0]};
            n_pending = 2'd1;
        end else begin
            has_pt = 1'b1;
        end
        n_bom_sent = 1'b1;
        if (i_in.end_of_text) begin
            n_pending  = 2'd0;
            n_point    = '0;
            n_bom_sent = 1'b0;
        end
    end

    assign emit_bom = !r_bom_sent && r_add_bom;
    assign term     = i_in.end_of_text && r_add_term;
    assign marker   = i_in.end_of_text && !emit_bom && !has_pt && !term;

    always_comb begin
        o_job.bom    = emit_bom;
        o_job.term   = term;
        o_job.marker = marker;
        o_job.eot    = i_in.end_of_text;
        if (!has_pt) begin
            o_job.num_units = 2'd0;
            o_job.unit0     = cp[15:0];
            o_job.unit1     = cp[15:0];
        end else if (cp[20:16] == 5'd0) begin
            o_job.num_units = 2'd1;
            o_job.unit0     = cp[15:0];
            o_job.unit1     = cp[15:0];
        end else begin
            o_job.num_units = 2'd2;
            o_job.unit0     = {HIGH_SURR_TAG, offs[19:10]};
            o_job.unit1     = {LOW_SURR_TAG, offs[9:0]};
        end
    end

    assign o_job_push = i_accept && (emit_bom || has_pt || term || marker);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_point    <= '0;
            r_bom_sent <= 1'b0;
            r_add_term <= 1'b0;
            r_add_bom  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_pending  <= n_pending;
                r_point    <= n_point;
                r_bom_sent <= n_bom_sent;
            end
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_ADD_TERMINATOR:      r_add_term <= i_cfg_data;
                    CFG_ADD_BYTE_ORDER_MARK: r_add_bom  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Short register queue of jobs between the decoder and the unit sequencer.
// ----------------------------------------------------------------------------
module u2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  u2u_pkg::t_job i_wr_data,
    output logic          o_full,
    input  logic          i_rd_en,
    output u2u_pkg::t_job o_rd_data,
    output logic          o_empty
);
    import u2u_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Unit sequencer: walks the results of each job into the output register.
// ----------------------------------------------------------------------------
module u2u_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  u2u_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic               i_out_pop,
    output logic               o_out_empty,
    output u2u_pkg::t_out_item o_out
);
    import u2u_pkg::*;

    logic [1:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [2:0] num_results;
    logic [1:0] unit_idx;
    logic       last;
    logic       advance;
    t_out_item  n_out;

    assign num_results = {2'd0, i_job.bom} + {1'b0, i_job.num_units}
                       + {2'd0, i_job.term} + {2'd0, i_job.marker};
    assign unit_idx    = r_step - {1'b0, i_job.bom};
    assign last        = ({1'b0, r_step} == num_results - 3'd1);
    assign advance     = !i_job_empty && (!r_out_valid || i_out_pop);

    always_comb begin
        n_out.last_in_run = last;
        n_out.text_done   = last && i_job.eot;
        n_out.unit_valid  = 1'b1;
        if (i_job.bom && r_step == 2'd0) begin
            n_out.code_unit = BYTE_ORDER_MARK;
        end else if (unit_idx < i_job.num_units) begin
            n_out.code_unit = (unit_idx == 2'd0) ? i_job.unit0 : i_job.unit1;
        end else if (i_job.term) begin
            n_out.code_unit = '0;
        end else begin
            n_out.code_unit  = '0;
            n_out.unit_valid = 1'b0;
        end
    end

    assign o_job_pop   = advance && last;
    assign o_out_empty = !r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step      <= last ? 2'd0 : r_step + 2'd1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/utf8_to_utf16_transcoder.sv
// With the sequencer idle, the first result of a byte is written to the job queue on the
// edge that accepts the byte and reaches the output ports through the output register.
// Throughput: one byte per cycle in while full is low; the sequencer emits one
// result per cycle while the receiver pops, so a byte holds the back end until all
// its results are out and the job queue (QUEUE_DEPTH entries) takes up the difference.
// Reset: synchronous, active low; clears decoder state, config, queue and output.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, with optional BOM and terminator.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  u2u_pkg::t_in_item             i_in,
    output logic                          empty,
    input  logic                          pop,
    output u2u_pkg::t_out_item            o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [u2u_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);
    import u2u_pkg::*;

    logic accept;
    logic job_push;
    logic job_pop;
    logic job_empty;
    t_job wr_job;
    t_job rd_job;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (job_push),
        .o_job       (wr_job)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (job_push),
        .i_wr_data (wr_job),
        .o_full    (full),
        .i_rd_en   (job_pop),
        .o_rd_data (rd_job),
        .o_empty   (job_empty)
    );

    u2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (rd_job),
        .o_job_pop   (job_pop),
        .i_out_pop   (pop),
        .o_out_empty (empty),
        .o_out       (o_out)
    );

endmodule

>>> rtl/u2u_checker.sv
// ----------------------------------------------------------------------------
// u2u_checker
// Port-level checks on the result side of the transcoder.
// ----------------------------------------------------------------------------
module u2u_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input u2u_pkg::t_out_item o_out
);
    import u2u_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out))
        else $error("stalled transaction changed");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out.unit_valid |-> o_out.last_in_run && o_out.text_done)
        else $error("bare end marker not last of text");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.text_done |-> o_out.last_in_run)
        else $error("text done without last in run");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

>>> bench/utf8_to_utf16_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Drives UTF-8 byte streams into the transcoder and checks every UTF-16 result
// against a cycle-free model of the conversion. Directed tests cover single
// bytes, all sequence lengths, surrogate pairs, cut-off text, the byte order
// mark and the terminator; random texts then run under three idle patterns
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;

    import u2u_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    t_in_item             i_in        = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                 i_cfg_data  = 1'b0;

    // conversion model state
    logic [1:0]  cont_left   = '0;
    logic [20:0] point_acc   = '0;
    logic        bom_decided = 1'b0;
    logic        cfg_term    = 1'b0;
    logic        cfg_bom     = 1'b0;

    t_out_item unit_queue [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    int results_checked = 0;
    int errors = 0;
    int full_stalls = 0;
    int cycles = 0;
    logic receiver_held = 1'b0;
    event hold_go;

    utf8_to_utf16_transcoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, unit_queue.size());
            $display("utf8_to_utf16_transcoder_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (receiver_held) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial forever begin
        @(hold_go);
        receiver_held <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        receiver_held <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && full) begin
            full_stalls++;
        end
    end

    function automatic t_out_item make_unit(input logic [15:0] code, input logic valid);
        t_out_item r;
        r = '0;
        r.code_unit  = code;
        r.unit_valid = valid;
        return r;
    endfunction

    // expected results for one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic eot);
        t_out_item   r [4];
        int          n;
        logic [20:0] cp;
        logic        have_cp;
        logic [19:0] off;
        n = 0;
        have_cp = 1'b0;
        cp = '0;
        if (!bom_decided) begin
            if (cfg_bom) begin
                r[n] = make_unit(BYTE_ORDER_MARK, 1'b1);
                n++;
            end
            bom_decided = 1'b1;
        end
        if (cont_left != 0) begin
            point_acc = {point_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
                cp = point_acc;
                have_cp = 1'b1;
                point_acc = '0;
            end
        end else if (b[7:3] == 5'b11110) begin
            point_acc = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else if (b[7:4] == 4'b1110) begin
            point_acc = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b[7:5] == 3'b110) begin
            point_acc = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else begin
            cp = {13'd0, b};
            have_cp = 1'b1;
        end
        if (have_cp) begin
            if (cp[20:16] == 0) begin
                r[n] = make_unit(cp[15:0], 1'b1);
                n++;
            end else begin
                off = 20'(cp - PLANE_ONE_BASE);
                r[n] = make_unit({HIGH_SURR_TAG, off[19:10]}, 1'b1);
                r[n+1] = make_unit({LOW_SURR_TAG, off[9:0]}, 1'b1);
                n += 2;
            end
        end
        if (eot) begin
            cont_left = '0;
            point_acc = '0;
            if (cfg_term) begin
                r[n] = make_unit(16'h0000, 1'b1);
                n++;
            end
            if (n == 0) begin
                r[n] = make_unit(16'h0000, 1'b0);
                n++;
            end
            bom_decided = 1'b0;
            r[n-1].text_done = 1'b1;
        end
        if (n > 0) begin
            r[n-1].last_in_run = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            unit_queue.push_back(r[k]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (unit_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out);
                errors++;
            end else begin
                want = unit_queue.pop_front();
                results_checked++;
                check_field("code_unit", want.code_unit, o_out.code_unit);
                check_field("unit_valid", want.unit_valid, o_out.unit_valid);
                check_field("last_in_run", want.last_in_run, o_out.last_in_run);
                check_field("text_done", want.text_done, o_out.text_done);
            end
        end
    end

    // push stays high on return so back-to-back bytes need no extra assignment
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < snd_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{text_byte: b, end_of_text: eot};
        do @(posedge i_clk); while (full);
        predict_byte(b, eot);
        bytes_sent++;
        if (eot) begin
            texts_sent++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (unit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ADD_TERMINATOR: begin
                cfg_term = val;
            end
            CFG_ADD_BYTE_ORDER_MARK: begin
                cfg_bom = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_text(input logic [7:0] txt [$]);
        foreach (txt[k]) begin
            send_byte(txt[k], k == txt.size() - 1);
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic send_random_text(input int max_chars);
        logic [7:0] txt [$];
        int         nchar;
        int         kind;
        nchar = $urandom_range(max_chars, 1);
        for (int c = 0; c < nchar; c++) begin
            kind = $urandom_range(99);
            if (kind < 28) begin
                txt.push_back(8'($urandom_range(8'h7F)));
            end else if (kind < 48) begin
                txt.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                txt.push_back(cont_byte());
            end else if (kind < 68) begin
                txt.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                txt.push_back(cont_byte());
                txt.push_back(cont_byte());
            end else if (kind < 88) begin
                txt.push_back(8'($urandom_range(8'hF7, 8'hF0)));
                txt.push_back(cont_byte());
                txt.push_back(cont_byte());
                txt.push_back(cont_byte());
            end else begin
                txt.push_back(8'($urandom_range(255)));
            end
        end
        // cut the text short now and then
        if ($urandom_range(9) == 0 && txt.size() > 1) begin
            void'(txt.pop_back());
        end
        send_text(txt);
    endtask

    task automatic run_random_phase(input int n_bytes, input int snd_pct, input int rcv_pct);
        int target;
        target = bytes_sent + n_bytes;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        while (bytes_sent < target) begin
            send_random_text(12);
        end
    endtask

    task automatic test_single_bytes();
        write_reg(CFG_ADD_TERMINATOR, 1'b0);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b0);
        send_text('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF});
    endtask

    task automatic test_multibyte_sequences();
        write_reg(CFG_ADD_TERMINATOR, 1'b1);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b1);
        // two, three and four byte forms, then the widest four byte value
        send_text('{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'hF7, 8'hBF, 8'hBF, 8'hBF});
    endtask

    task automatic test_truncated_end();
        write_reg(CFG_ADD_TERMINATOR, 1'b0);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b0);
        send_text('{8'hE2, 8'h82});
        send_text('{8'hF0});
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b1);
        send_text('{8'hF0});
    endtask

    task automatic test_bom_mid_text();
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b0);
        send_byte(8'h41, 1'b0);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b1);
        send_byte(8'h42, 1'b1);
        send_text('{8'h43});
    endtask

    task automatic test_spare_index();
        write_reg(CFG_SPARE_A, 1'b1);
        write_reg(CFG_SPARE_B, 1'b1);
        send_text('{8'h5A});
    endtask

    task automatic test_backpressure();
        write_reg(CFG_ADD_TERMINATOR, 1'b1);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b1);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        -> hold_go;
        run_random_phase(40, 0, 0);
    endtask

    initial begin
        snd_idle_pct = 14;
        rcv_idle_pct = 49;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_multibyte_sequences();
        test_truncated_end();
        test_bom_mid_text();
        test_spare_index();

        write_reg(CFG_ADD_TERMINATOR, 1'b1);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b0);
        run_random_phase(110, 14, 49);
        write_reg(CFG_ADD_TERMINATOR, 1'b0);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b1);
        run_random_phase(110, 49, 14);
        test_backpressure();
        write_reg(CFG_ADD_TERMINATOR, 1'b0);
        write_reg(CFG_ADD_BYTE_ORDER_MARK, 1'b0);
        run_random_phase(90, 0, 0);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts, checked %0d code unit results.",
                 bytes_sent, texts_sent, results_checked);
        $display("Input held off by full for %0d cycles; %0d errors.", full_stalls, errors);
        if (errors == 0) begin
            $display("utf8_to_utf16_transcoder_tb passed");
        end else begin
            $display("utf8_to_utf16_transcoder_tb failed");
        end
        $finish;
    end

endmodule
